@@ hdl/majority_clocked_lfsr_keystream_defines.svh @@
// Assertion macros shared by the keystream generator.
// Each checks on the rising edge of clock and is quiet while reset is high.
`ifndef MAJORITY_CLOCKED_LFSR_KEYSTREAM_DEFINES_SVH
`define MAJORITY_CLOCKED_LFSR_KEYSTREAM_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MCLK_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MCLK_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/mclk_pkg.sv @@
package mclk_pkg;

   // register geometry
   localparam int ONE_WIDTH   = 19;
   localparam int TWO_WIDTH   = 22;
   localparam int THREE_WIDTH = 23;

   // feedback taps
   localparam logic [ONE_WIDTH-1:0]   ONE_TAPS   = 19'h72000;
   localparam logic [TWO_WIDTH-1:0]   TWO_TAPS   = 22'h300000;
   localparam logic [THREE_WIDTH-1:0] THREE_TAPS = 23'h700080;

   // clocking bits
   localparam int ONE_MID   = 8;
   localparam int TWO_MID   = 10;
   localparam int THREE_MID = 10;

   // key slicing
   localparam int KEY_WIDTH     = 64;
   localparam int KEY_ONE_LOW   = 45;
   localparam int KEY_TWO_LOW   = 23;
   localparam int KEY_THREE_LOW = 0;

   // result bus width, one byte
   localparam int RSP_DATA_WIDTH = 8;

   // request kinds carried on tuser
   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   // per-register control handed to each cell
   typedef struct packed {
      logic load;
      logic shift;
   } lfsr_ctrl_type;

endpackage

@@ hdl/mclk_cell.sv @@
// One stage of a shift register: holds a single bit, takes a parallel
// load or its neighbor's bit on a shift.
module mclk_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mclk_pkg::lfsr_ctrl_type ctrl,
   input  logic                   load_value,
   input  logic                   shift_value,
   output logic                   store
);

   logic store_ff;
   logic store_in;

   // load wins over shift; they never coincide in practice
   always_comb begin
      store_in = store_ff;
      if (ctrl.load) begin
         store_in = load_value;
      end else if (ctrl.shift) begin
         store_in = shift_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= 1'b0;
      end else begin
         store_ff <= store_in;
      end
   end

   assign store = store_ff;

endmodule

@@ hdl/mclk_lfsr.sv @@
// Fibonacci LFSR built as a row of bit cells; parity of the taps enters
// at bit 0 and every cell passes its bit one place up on a shift.
module mclk_lfsr #(
   parameter int               WIDTH   = mclk_pkg::ONE_WIDTH,
   parameter logic [WIDTH-1:0] TAPS    = mclk_pkg::ONE_TAPS,
   parameter int               MID_BIT = mclk_pkg::ONE_MID
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mclk_pkg::lfsr_ctrl_type ctrl,
   input  logic [WIDTH-1:0]        load_value,
   output logic [WIDTH-1:0]        state,
   output logic                    top_bit,
   output logic                    mid_bit
);

   logic             feedback;
   logic [WIDTH-1:0] shift_value;

   // tap parity and neighbor wiring
   assign feedback    = ^(state & TAPS);
   assign shift_value = {state[WIDTH-2:0], feedback};

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      mclk_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .load_value  (load_value[i]),
         .shift_value (shift_value[i]),
         .store       (state[i])
      );
   end

   assign top_bit = state[WIDTH-1];
   assign mid_bit = state[MID_BIT];

endmodule

@@ hdl/majority_clocked_lfsr_keystream.sv @@
// A step request shows its keystream bit on rsp in the cycle after it is accepted.
// Throughput: one request per cycle while rsp is not stalled; each LFSR is a row of bit cells that update together.
// A load request yields no response and takes effect for the request that follows it.
// req_tready drops only while a response waits and rsp_tready is low.
// Reset (synchronous, active high) clears all three registers to zero and empties rsp.
`include "majority_clocked_lfsr_keystream_defines.svh"

module majority_clocked_lfsr_keystream (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // key_value [63:0]
   input  logic [mclk_pkg::KEY_WIDTH-1:0]        req_tdata,
   // operation [0]
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // keystream_bit [0], zeros above
   output logic [mclk_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata
);

   logic req_fire;
   logic step_fire;
   logic load_fire;

   logic [mclk_pkg::ONE_WIDTH-1:0]   one_state;
   logic [mclk_pkg::TWO_WIDTH-1:0]   two_state;
   logic [mclk_pkg::THREE_WIDTH-1:0] three_state;
   logic one_top, two_top, three_top;
   logic one_mid, two_mid, three_mid;
   logic majority;
   logic keystream;
   logic [2:0] shift_vec;

   mclk_pkg::lfsr_ctrl_type one_ctrl, two_ctrl, three_ctrl;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_bit_ff, rsp_bit_in;

   // request handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign step_fire  = req_fire && (req_tuser == mclk_pkg::OP_STEP);
   assign load_fire  = req_fire && (req_tuser == mclk_pkg::OP_LOAD);

   // majority clock control
   assign majority  = (one_mid & two_mid) | (one_mid & three_mid) | (two_mid & three_mid);
   assign keystream = one_top ^ two_top ^ three_top;

   assign one_ctrl.load    = load_fire;
   assign two_ctrl.load    = load_fire;
   assign three_ctrl.load  = load_fire;
   assign one_ctrl.shift   = step_fire && (one_mid == majority);
   assign two_ctrl.shift   = step_fire && (two_mid == majority);
   assign three_ctrl.shift = step_fire && (three_mid == majority);
   assign shift_vec        = {one_ctrl.shift, two_ctrl.shift, three_ctrl.shift};

   // the three registers
   mclk_lfsr #(
      .WIDTH   (mclk_pkg::ONE_WIDTH),
      .TAPS    (mclk_pkg::ONE_TAPS),
      .MID_BIT (mclk_pkg::ONE_MID)
   ) u_one (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (one_ctrl),
      .load_value (req_tdata[mclk_pkg::KEY_ONE_LOW +: mclk_pkg::ONE_WIDTH]),
      .state      (one_state),
      .top_bit    (one_top),
      .mid_bit    (one_mid)
   );

   mclk_lfsr #(
      .WIDTH   (mclk_pkg::TWO_WIDTH),
      .TAPS    (mclk_pkg::TWO_TAPS),
      .MID_BIT (mclk_pkg::TWO_MID)
   ) u_two (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (two_ctrl),
      .load_value (req_tdata[mclk_pkg::KEY_TWO_LOW +: mclk_pkg::TWO_WIDTH]),
      .state      (two_state),
      .top_bit    (two_top),
      .mid_bit    (two_mid)
   );

   mclk_lfsr #(
      .WIDTH   (mclk_pkg::THREE_WIDTH),
      .TAPS    (mclk_pkg::THREE_TAPS),
      .MID_BIT (mclk_pkg::THREE_MID)
   ) u_three (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (three_ctrl),
      .load_value (req_tdata[mclk_pkg::KEY_THREE_LOW +: mclk_pkg::THREE_WIDTH]),
      .state      (three_state),
      .top_bit    (three_top),
      .mid_bit    (three_mid)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;
      if (step_fire) begin
         rsp_valid_in = 1'b1;
         rsp_bit_in   = keystream;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mclk_pkg::RSP_DATA_WIDTH-1){1'b0}}, rsp_bit_ff};

   // checks; the three registers side by side cover the whole key
   `MCLK_ASSERT_NEXT(a_step_gives_rsp, step_fire, rsp_valid_ff, "step lost its response")
   `MCLK_ASSERT_NEXT(a_rsp_bit, step_fire, rsp_bit_ff == $past(keystream), "wrong keystream bit")
   `MCLK_ASSERT_NOW(a_majority_clocks, step_fire, $countones(shift_vec) >= 2, "fewer than two clocked")
   `MCLK_ASSERT_NEXT(a_load_regs, load_fire, {one_state, two_state, three_state} == $past(req_tdata), "register load mismatch")
   `MCLK_ASSERT_NOW(a_no_overrun, rsp_valid_ff && !rsp_tready, !req_tready, "request over full rsp")

endmodule

@@ sim/majority_clocked_lfsr_keystream_tb.sv @@
`timescale 1ns / 100ps

module majority_clocked_lfsr_keystream_tb;
   import mclk_pkg::*;

   localparam int RANDOM_ITEMS   = 600;
   localparam int QUIET_ITEMS    = 80;   // tail of the run without idling
   localparam int HOLD_AFTER     = 150;  // requests accepted before the long rsp stall
   localparam int HOLD_CYCLES    = 90;
   localparam int PAUSE_AT       = 320;  // random item at which the sender drains
   localparam int WATCHDOG_LIMIT = 1000;

   // directed stimulus row; ks_known marks a keystream bit typed in by hand
   typedef struct packed {
      op_type                op;
      logic [KEY_WIDTH-1:0]  key;
      logic                  ks_known;
      logic                  ks;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [KEY_WIDTH-1:0]        req_tdata = '0;
   logic                        req_tuser = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;

   // shadow copies of the three shift registers
   logic [ONE_WIDTH-1:0]        sr19;
   logic [TWO_WIDTH-1:0]        sr22;
   logic [THREE_WIDTH-1:0]      sr23;

   logic                        keystream_expected[$];
   int                          error_count = 0;
   int                          accepted_requests = 0;
   int                          idle_cycles = 0;
   bit                          tail_phase = 1'b0;

   stim_row_type directed [DIRECTED_ROWS] = '{
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b1, 1'b0},  // step straight out of reset
      '{OP_STEP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},  // key bus ignored on a step
      '{OP_LOAD, 64'h0000_0000_0000_0000, 1'b0, 1'b0},
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b1, 1'b0},
      '{OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b1, 1'b1},  // all top bits set
      '{OP_STEP, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0},
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b0, 1'b0},
      '{OP_LOAD, 64'h8000_0000_0000_0000, 1'b0, 1'b0},  // first register MSB only
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b1, 1'b1},
      '{OP_LOAD, 64'h0000_1000_0000_0000, 1'b0, 1'b0},  // second register MSB only
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b1, 1'b1},
      '{OP_LOAD, 64'h0000_0000_0040_0000, 1'b0, 1'b0},  // third register MSB only
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b1, 1'b1},
      '{OP_LOAD, 64'h0020_0000_0000_0000, 1'b0, 1'b0},  // first middle bit in minority
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b0, 1'b0},
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b0, 1'b0},
      '{OP_LOAD, 64'h0000_0002_0000_0000, 1'b0, 1'b0},  // overwritten by the next load
      '{OP_LOAD, 64'h0000_0000_0000_0400, 1'b0, 1'b0},  // third middle bit in minority
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b0, 1'b0},
      '{OP_STEP, 64'h0000_0000_0000_0000, 1'b0, 1'b0},
      '{OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0},
      '{OP_STEP, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
      '{OP_LOAD, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
      '{OP_STEP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0}
   };

   majority_clocked_lfsr_keystream uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // apply one request to the shadow registers; a step returns its keystream bit
   task automatic advance_keystream(input op_type op, input logic [KEY_WIDTH-1:0] key,
                                    output logic has_bit, output logic ks_bit);
      logic m1, m2, m3, maj;
      has_bit = 1'b0;
      ks_bit  = 1'b0;
      if (op == OP_LOAD) begin
         sr19 = key[KEY_ONE_LOW +: ONE_WIDTH];
         sr22 = key[KEY_TWO_LOW +: TWO_WIDTH];
         sr23 = key[KEY_THREE_LOW +: THREE_WIDTH];
      end else begin
         ks_bit  = sr19[ONE_WIDTH-1] ^ sr22[TWO_WIDTH-1] ^ sr23[THREE_WIDTH-1];
         has_bit = 1'b1;
         m1  = sr19[ONE_MID];
         m2  = sr22[TWO_MID];
         m3  = sr23[THREE_MID];
         maj = (m1 & m2) | (m1 & m3) | (m2 & m3);
         // stop/go: only registers agreeing with the majority shift
         if (m1 == maj) sr19 = {sr19[ONE_WIDTH-2:0], ^(sr19 & ONE_TAPS)};
         if (m2 == maj) sr22 = {sr22[TWO_WIDTH-2:0], ^(sr22 & TWO_TAPS)};
         if (m3 == maj) sr23 = {sr23[THREE_WIDTH-2:0], ^(sr23 & THREE_TAPS)};
      end
   endtask

   // offer one request and hold it until accepted
   task automatic send_request(input op_type op, input logic [KEY_WIDTH-1:0] key,
                               input logic ks_known, input logic ks_typed);
      logic has_bit, ks_bit;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accepted_requests++;
      advance_keystream(op, key, has_bit, ks_bit);
      if (has_bit) keystream_expected.push_back(ks_known ? ks_typed : ks_bit);
   endtask

   // random idle burst on the request side
   task automatic sender_gap();
      if (!tail_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // request side
   initial begin
      logic [KEY_WIDTH-1:0] key;
      op_type               op;
      sr19 = '0;
      sr22 = '0;
      sr23 = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         sender_gap();
         send_request(directed[i].op, directed[i].key, directed[i].ks_known, directed[i].ks);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - QUIET_ITEMS) tail_phase = 1'b1;
         if (i == PAUSE_AT) begin
            // drain: hold off until every keystream bit is back
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (keystream_expected.size() != 0) @(posedge clock);
         end else begin
            sender_gap();
         end
         key = {$urandom, $urandom};
         op  = ($urandom_range(0, 9) == 0) ? OP_LOAD : OP_STEP;
         if (op == OP_LOAD && $urandom_range(0, 15) == 0)
            key = $urandom_range(0, 1) ? '1 : '0;
         send_request(op, key, 1'b0, 1'b0);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (keystream_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // response side: random stalls, one long stall, none in the tail
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && accepted_requests >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // compare each keystream bit with the oldest prediction
   always @(posedge clock) begin
      logic exp_bit;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (keystream_expected.size() == 0) begin
            report_mismatch($sformatf("keystream bit %0b with none pending", rsp_tdata[0]));
         end else begin
            exp_bit = keystream_expected.pop_front();
            if (rsp_tdata[0] !== exp_bit)
               report_mismatch($sformatf("keystream_bit got %b want %b",
                                         rsp_tdata[0], exp_bit));
            if (rsp_tdata[RSP_DATA_WIDTH-1:1] !== '0)
               report_mismatch($sformatf("rsp_tdata padding not zero: %h", rsp_tdata));
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TIMEOUT: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mclk_pkg.sv
hdl/mclk_cell.sv
hdl/mclk_lfsr.sv
hdl/majority_clocked_lfsr_keystream.sv
sim/majority_clocked_lfsr_keystream_tb.sv
